### sv/gcrt_pkg.sv
// Package for the grid cell reservation table.
// Holds the sequencer state type, the map entry type and the operation codes.
// No dependencies.
`default_nettype none

package gcrt_pkg;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_SWEEP,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       used;
        logic [1:0] robot;
    } t_entry;

    localparam logic [1:0] OP_CLAIM   = 2'd0;
    localparam logic [1:0] OP_QUERY   = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

endpackage

`default_nettype wire

### sv/grid_cell_reservation_table.sv
// Grid cell reservation table: per-cell owner map in memory, driven by a small sequencer.
// A release with a valid robot sweeps every cell. One transaction in flight, ready only in idle;
// a full output register holds DONE. Reset (i_rst_n low, synchronous) starts a clearing pass,
// one cell per cycle, during which no input transaction is taken. Depends on gcrt_pkg.
`default_nettype none

module grid_cell_reservation_table #(
    parameter int GRID_ROWS   = 16,
    parameter int GRID_COLS   = 16,
    parameter int ROBOT_COUNT = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input channel
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_operation,
    input  wire logic [1:0] i_robot,
    input  wire logic [3:0] i_row,
    input  wire logic [3:0] i_col,
    // result channel
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_granted,
    output logic            o_cell_free,
    output logic [1:0]      o_cell_owner,
    output logic [7:0]      o_released_count
);
    import gcrt_pkg::*;

    // Cell count and address width; the index is row * GRID_COLS + col.
    localparam int CELLS = GRID_ROWS * GRID_COLS;
    localparam int CW    = $clog2(CELLS);
    localparam int IW    = CW + 8;
    localparam logic [CW-1:0] LAST = CW'(CELLS - 1);

    // Owner map: one write port and one registered read port.
    t_entry r_mem [CELLS];
    t_entry r_rd_data;

    logic [CW-1:0] w_rd_addr;
    logic          w_we;
    logic [CW-1:0] w_wa;
    t_entry        w_wd;

    t_state r_state, n_state;

    // Latched transaction fields.
    logic [1:0]    r_op;
    logic [1:0]    r_robot;
    logic [CW-1:0] r_idx;
    logic          r_in_grid;
    logic          r_robot_ok;

    // Sweep address counter (also used by the clearing pass) and read pipeline tag.
    logic [CW-1:0] r_cnt;
    logic          r_sw_vld;
    logic [CW-1:0] r_sw_addr;

    // Result held until it moves to the output register.
    logic       r_res_granted;
    logic       r_res_free;
    logic [1:0] r_res_owner;
    logic [7:0] r_rel_cnt;

    // Output register.
    logic       r_out_vld;
    logic       r_granted;
    logic       r_free;
    logic [1:0] r_owner;
    logic [7:0] r_released;

    // Decode of the incoming transaction.
    logic [IW-1:0] w_idx_wide;
    logic [CW-1:0] w_idx;
    logic          w_in_grid;
    logic          w_robot_ok;

    assign w_idx_wide = IW'(i_row) * IW'(GRID_COLS) + IW'(i_col);
    assign w_idx      = w_idx_wide[CW-1:0];
    assign w_in_grid  = ({28'd0, i_row} < 32'(GRID_ROWS)) && ({28'd0, i_col} < 32'(GRID_COLS));
    assign w_robot_ok = {30'd0, i_robot} < 32'(ROBOT_COUNT);

    // Lookup evaluation: the claimed or named cell after this operation.
    logic   w_do_claim;
    t_entry w_after;

    assign w_do_claim = (r_op == OP_CLAIM) && r_in_grid && r_robot_ok && !r_rd_data.used;

    always_comb begin
        w_after = r_rd_data;
        if (w_do_claim) begin
            w_after.used  = 1'b1;
            w_after.robot = r_robot;
        end
    end

    // Sweep evaluation: a cell of this robot other than the kept one is freed.
    logic w_sw_match;

    assign w_sw_match = r_sw_vld && r_rd_data.used && (r_rd_data.robot == r_robot)
                        && !(r_in_grid && (r_sw_addr == r_idx));

    logic w_out_load;
    assign w_out_load = (r_state == S_DONE) && (!r_out_vld || i_out_ready);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_cnt == LAST) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_LOOK;
            end
            S_LOOK: begin
                if (r_op == OP_RELEASE && r_robot_ok) n_state = S_SWEEP;
                else n_state = S_DONE;
            end
            S_SWEEP: begin
                if (r_cnt == LAST) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Memory port control and input ready.
    always_comb begin
        o_in_ready = 1'b0;
        w_rd_addr  = r_idx;
        w_we       = 1'b0;
        w_wa       = r_idx;
        w_wd       = '0;
        unique case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
                w_wa = r_cnt;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                w_rd_addr  = w_idx;
            end
            S_LOOK: begin
                w_we = w_do_claim;
                w_wd = w_after;
            end
            S_SWEEP: begin
                w_rd_addr = r_cnt;
                w_we      = w_sw_match;
                w_wa      = r_sw_addr;
            end
            S_DRAIN: begin
                w_we = w_sw_match;
                w_wa = r_sw_addr;
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Map storage.
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        r_rd_data <= r_mem[w_rd_addr];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_cnt     <= '0;
            r_sw_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sw_vld <= (r_state == S_SWEEP);
            if (r_state == S_CLEAR || r_state == S_SWEEP) r_cnt <= r_cnt + 1'b1;
            if (r_state == S_LOOK) r_cnt <= '0;
            if (w_out_load) r_out_vld <= 1'b1;
            else if (i_out_ready) r_out_vld <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_op       <= i_operation;
            r_robot    <= i_robot;
            r_idx      <= w_idx;
            r_in_grid  <= w_in_grid;
            r_robot_ok <= w_robot_ok;
        end
        r_sw_addr <= r_cnt;
        if (r_state == S_LOOK) begin
            r_res_granted <= r_in_grid && w_after.used && (w_after.robot == r_robot);
            r_res_free    <= r_in_grid && !w_after.used;
            r_res_owner   <= (r_in_grid && w_after.used) ? w_after.robot : 2'd0;
            r_rel_cnt     <= '0;
        end else if (w_sw_match && r_rel_cnt != 8'hFF) begin
            r_rel_cnt <= r_rel_cnt + 8'd1;
        end
        if (w_out_load) begin
            r_granted  <= r_res_granted;
            r_free     <= r_res_free;
            r_owner    <= r_res_owner;
            r_released <= r_rel_cnt;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_granted        = r_granted;
    assign o_cell_free      = r_free;
    assign o_cell_owner     = r_owner;
    assign o_released_count = r_released;

endmodule

`default_nettype wire

### tb/grid_cell_reservation_table_tb.sv
// Testbench for grid_cell_reservation_table: directed table, full-grid fills and random
// claim/query/release traffic under varying idle and stall rates, checked against a local map.
// Depends on gcrt_pkg and grid_cell_reservation_table.

module grid_cell_reservation_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gcrt_pkg::*;

    localparam int CELLS = 16 * 16;
    // Code 3 has no name in the package; the block treats it as a query.
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic       granted;
        logic       cell_free;
        logic [1:0] owner;
        logic [7:0] released;
    } t_result;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] robot;
        logic [3:0] row;
        logic [3:0] col;
        logic       fixed;     // answer below is typed in, not predicted
        t_result    answer;
    } t_request;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       in_valid    = 1'b0;
    logic [1:0] in_op       = OP_QUERY;
    logic [1:0] in_robot    = 2'd0;
    logic [3:0] in_row      = 4'd0;
    logic [3:0] in_col      = 4'd0;
    logic       out_ready   = 1'b0;

    logic       o_in_ready;
    logic       o_out_valid;
    logic       o_granted;
    logic       o_cell_free;
    logic [1:0] o_cell_owner;
    logic [7:0] o_released_count;

    // Local copy of the owner map, indexed by {row, col}.
    t_entry     owner_map [CELLS];
    t_result    pending_results [$];
    t_request   directed_rows [$];
    int         mismatch_count = 0;
    int         in_idle_pct    = 0;
    int         out_stall_pct  = 0;

    grid_cell_reservation_table i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (in_op),
        .i_robot          (in_robot),
        .i_row            (in_row),
        .i_col            (in_col),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_granted        (o_granted),
        .o_cell_free      (o_cell_free),
        .o_cell_owner     (o_cell_owner),
        .o_released_count (o_released_count)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_request mk_req(logic [1:0] op, logic [1:0] robot, logic [3:0] row,
                                        logic [3:0] col, logic fixed = 1'b0,
                                        logic g = 1'b0, logic f = 1'b0,
                                        logic [1:0] o = 2'd0, logic [7:0] n = 8'd0);
        t_request rq;
        rq.op     = op;
        rq.robot  = robot;
        rq.row    = row;
        rq.col    = col;
        rq.fixed  = fixed;
        rq.answer = {g, f, o, n};
        return rq;
    endfunction

    // Appends one row to the directed table.
    function automatic void add_row(t_request rq);
        directed_rows.insert(directed_rows.size(), rq);
    endfunction

    // Appends one expectation behind the ones still outstanding.
    function automatic void queue_result(t_result r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Applies one transaction to the local map and returns the result it must produce.
    function automatic t_result apply_request(t_request rq);
        int unsigned idx;
        int unsigned freed;
        int          i;
        t_result     r;
        idx   = 32'({rq.row, rq.col});
        freed = 0;
        case (rq.op)
            OP_CLAIM: begin
                // first come wins; an owned cell is left alone
                if (!owner_map[idx].used) begin
                    owner_map[idx].used  = 1'b1;
                    owner_map[idx].robot = rq.robot;
                end
            end
            OP_RELEASE: begin
                // free every cell of this robot except the one it reports
                for (i = 0; i < CELLS; i++) begin
                    if (owner_map[i].used && owner_map[i].robot == rq.robot && i != idx) begin
                        owner_map[i].used  = 1'b0;
                        owner_map[i].robot = 2'd0;
                        freed++;
                    end
                end
            end
            default: ;  // query and the spare code leave the map alone
        endcase
        r.granted   = owner_map[idx].used && owner_map[idx].robot == rq.robot;
        r.cell_free = !owner_map[idx].used;
        r.owner     = owner_map[idx].used ? owner_map[idx].robot : 2'd0;
        r.released  = (rq.op != OP_RELEASE) ? 8'd0 : (freed > 255) ? 8'd255 : freed[7:0];
        return r;
    endfunction

    // Drives one transaction, waits for it to be taken and queues its expected result.
    task automatic send(input t_request rq);
        t_result predicted;
        if ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < in_idle_pct) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_op    <= rq.op;
        in_robot <= rq.robot;
        in_row   <= rq.row;
        in_col   <= rq.col;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = apply_request(rq);
        queue_result(rq.fixed ? rq.answer : predicted);
    endtask

    function automatic t_request random_request();
        t_request    rq;
        int unsigned pick;
        rq   = '0;
        pick = $urandom_range(99);
        if (pick < 55)      rq.op = OP_CLAIM;
        else if (pick < 72) rq.op = OP_QUERY;
        else if (pick < 77) rq.op = OP_SPARE;
        else                rq.op = OP_RELEASE;
        rq.robot = 2'($urandom_range(3));
        if ($urandom_range(1)) begin
            rq.row = 4'($urandom_range(15));
            rq.col = 4'($urandom_range(15));
        end else begin
            // small hot spot so robots contend and reports land on owned cells
            rq.row = 4'($urandom_range(9, 6));
            rq.col = 4'($urandom_range(9, 6));
        end
        return rq;
    endfunction

    // Strips the other robots of all cells, lets one robot claim the whole grid, then
    // has it report a position: the largest possible release count.
    task automatic fill_grid(input logic [1:0] holder);
        logic [1:0] other;
        logic [3:0] keep_row;
        logic [3:0] keep_col;
        int         k;
        int         c;
        for (k = 1; k < 4; k++) begin
            other = holder + k[1:0];
            send(mk_req(OP_RELEASE, other, 4'd3, 4'd12));
            send(mk_req(OP_RELEASE, other, 4'd12, 4'd3));
        end
        for (c = 0; c < CELLS; c++) send(mk_req(OP_CLAIM, holder, c[7:4], c[3:0]));
        keep_row = 4'($urandom_range(15));
        keep_col = 4'($urandom_range(15));
        send(mk_req(OP_RELEASE, holder, keep_row, keep_col, 1'b1, 1'b1, 1'b0, holder, 8'd255));
    endtask

    function automatic void note_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%0t: %s", $time, what);
    endfunction

    // Result side: check each transaction against the oldest expectation, randomize ready.
    always @(posedge i_clk) begin : result_check
        t_result seen;
        t_result want;
        if (i_rst_n && o_out_valid && out_ready) begin
            seen = {o_granted, o_cell_free, o_cell_owner, o_released_count};
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("unexpected result %p", seen));
            end else begin
                want = pending_results.pop_front();
                if (seen.granted !== want.granted || seen.cell_free !== want.cell_free ||
                    seen.owner !== want.owner || seen.released !== want.released) begin
                    note_mismatch($sformatf("expected %p, got %p", want, seen));
                end
            end
        end
        out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    initial begin : stimulus
        int       phase;

        // Directed rows: typed answers where they are obvious, predicted otherwise.
        add_row(mk_req(OP_QUERY,   2'd0, 4'd0,  4'd0,  1'b1, 1'b0, 1'b1, 2'd0, 8'd0));
        add_row(mk_req(OP_CLAIM,   2'd3, 4'd15, 4'd15, 1'b1, 1'b1, 1'b0, 2'd3, 8'd0));
        add_row(mk_req(OP_CLAIM,   2'd0, 4'd15, 4'd15, 1'b1, 1'b0, 1'b0, 2'd3, 8'd0));
        add_row(mk_req(OP_CLAIM,   2'd3, 4'd15, 4'd15, 1'b1, 1'b1, 1'b0, 2'd3, 8'd0));
        add_row(mk_req(OP_CLAIM,   2'd0, 4'd0,  4'd0,  1'b1, 1'b1, 1'b0, 2'd0, 8'd0));
        add_row(mk_req(OP_CLAIM,   2'd0, 4'd0,  4'd15, 1'b1, 1'b1, 1'b0, 2'd0, 8'd0));
        add_row(mk_req(OP_CLAIM,   2'd0, 4'd15, 4'd0,  1'b1, 1'b1, 1'b0, 2'd0, 8'd0));
        add_row(mk_req(OP_QUERY,   2'd1, 4'd0,  4'd0,  1'b1, 1'b0, 1'b0, 2'd0, 8'd0));
        add_row(mk_req(OP_SPARE,   2'd0, 4'd0,  4'd0,  1'b1, 1'b1, 1'b0, 2'd0, 8'd0));
        // robot 0 reports (0,0): its two corner cells go
        add_row(mk_req(OP_RELEASE, 2'd0, 4'd0,  4'd0,  1'b1, 1'b1, 1'b0, 2'd0, 8'd2));
        add_row(mk_req(OP_QUERY,   2'd0, 4'd0,  4'd15, 1'b1, 1'b0, 1'b1, 2'd0, 8'd0));
        // robot 3 reports a cell held by robot 0: all of its own cells go
        add_row(mk_req(OP_RELEASE, 2'd3, 4'd0,  4'd0,  1'b1, 1'b0, 1'b0, 2'd0, 8'd1));
        add_row(mk_req(OP_QUERY,   2'd3, 4'd15, 4'd15, 1'b1, 1'b0, 1'b1, 2'd0, 8'd0));
        add_row(mk_req(OP_CLAIM,   2'd2, 4'd10, 4'd5,  1'b1, 1'b1, 1'b0, 2'd2, 8'd0));
        add_row(mk_req(OP_CLAIM,   2'd1, 4'd5,  4'd10, 1'b1, 1'b1, 1'b0, 2'd1, 8'd0));
        // report on the only owned cell: nothing freed
        add_row(mk_req(OP_RELEASE, 2'd1, 4'd5,  4'd10, 1'b1, 1'b1, 1'b0, 2'd1, 8'd0));
        // report on a free cell
        add_row(mk_req(OP_RELEASE, 2'd2, 4'd3,  4'd3,  1'b1, 1'b0, 1'b1, 2'd0, 8'd1));
        add_row(mk_req(OP_RELEASE, 2'd0, 4'd0,  4'd0,  1'b1, 1'b1, 1'b0, 2'd0, 8'd0));
        add_row(mk_req(OP_SPARE,   2'd3, 4'd10, 4'd5,  1'b1, 1'b0, 1'b1, 2'd0, 8'd0));
        add_row(mk_req(OP_CLAIM,   2'd1, 4'd10, 4'd5));
        add_row(mk_req(OP_QUERY,   2'd2, 4'd5,  4'd10));
        add_row(mk_req(OP_CLAIM,   2'd2, 4'd15, 4'd15));
        add_row(mk_req(OP_RELEASE, 2'd1, 4'd15, 4'd15));

        foreach (owner_map[i]) owner_map[i] = '0;

        // The block clears its map after reset; send() simply waits for ready.
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) send(directed_rows[k]);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 52; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 52; end
                default: begin in_idle_pct = 28; out_stall_pct = 28; end
            endcase
            if (phase == 0 || phase == 3) fill_grid(2'($urandom_range(3)));
            repeat (350) send(random_request());
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("grid_cell_reservation_table_tb: clean");
        end else begin
            $display("grid_cell_reservation_table_tb: errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, even with every transaction a sweep.
    initial begin
        #40_000_000;
        $display("grid_cell_reservation_table_tb: errors");
        $finish;
    end

endmodule

### grid_cell_reservation_table.f
sv/gcrt_pkg.sv
sv/grid_cell_reservation_table.sv
tb/grid_cell_reservation_table_tb.sv
